>>> rtl/shadow_flash_dirty_page_aging_defines.svh
// Assertion macros for the shadow flash dirty page aging block.
`ifndef SHADOW_FLASH_DIRTY_PAGE_AGING_DEFINES_SVH
`define SHADOW_FLASH_DIRTY_PAGE_AGING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SFDPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdpa assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SFDPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdpa assertion failed");

`endif

>>> rtl/sfdpa_pkg.sv
// Shared types and constants for the shadow flash dirty page aging block.
package sfdpa_pkg;

  localparam int SHADOW_BYTES = 16384;
  localparam int PAGE_BYTES   = 1024;
  localparam int PAGE_COUNT   = 16;

  localparam int OFF_W      = $clog2(SHADOW_BYTES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int OPG_W      = OFF_W - PAGE_SHIFT;
  localparam int PAGE_IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  localparam int AGE_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [7:0] OUTSIDE_BYTE = 8'hFF;

  localparam logic [31:0] BASE_RESET = 32'd0;
  localparam logic [31:0] END_RESET  = 32'd16384;
  localparam logic [15:0] THR_RESET  = 16'd10000;

  // config register indexes (byte address / 4)
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_END  = 2'd1;
  localparam logic [1:0] REG_THR  = 2'd2;

  localparam int PADDR_W = 4;

  // commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_PRELOAD = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [7:0]  write_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       commit_valid;
    logic [3:0] commit_page;
  } out_beat_t;

endpackage

>>> rtl/shadow_flash_dirty_page_aging.sv
// Top level: byte shadow of emulated flash with per-page dirty aging.
// Throughput: one beat in flight; the page walk of a tick (one age a cycle through
//   a single increment/compare unit) sets the tick cost, the shadow RAM read port the rest.
// Reset (rst, synchronous, active high): ages zero, scan pointer zero, registers to
//   defaults; shadow contents undefined until written or preloaded.
`include "shadow_flash_dirty_page_aging_defines.svh"

module shadow_flash_dirty_page_aging
  import sfdpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  input  in_beat_t           in_data,
  output logic               in_stall,
  // result channel
  output logic               out_valid,
  output out_beat_t          out_data,
  input  logic               out_stall,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1; // window compare, offset
  localparam logic [2:0] ST_MEMRD = 3'd2; // shadow read in flight
  localparam logic [2:0] ST_MEMCMP = 3'd3; // compare / write back / mark
  localparam logic [2:0] ST_SCAN  = 3'd4; // one page per cycle
  localparam logic [2:0] ST_DONE  = 3'd5; // wait for output slot

  logic [2:0] state;

  // config registers
  logic [31:0] window_base;
  logic [31:0] window_end;
  logic [15:0] age_threshold;

  // captured beat
  logic [1:0]  cmd;
  logic [31:0] addr;
  logic [7:0]  wbyte;

  // window check results
  logic             inwin;
  logic             page_ok;
  logic [OFF_W-1:0] off;
  logic [7:0]       rdata_q;

  // ages and scan
  logic [AGE_W-1:0]      page_age [PAGE_COUNT];
  logic [PAGE_IDX_W-1:0] age_idx;
  logic [PAGE_IDX_W-1:0] scan_ptr;
  logic [PAGE_IDX_W-1:0] scan_cnt;
  logic [PAGE_IDX_W-1:0] pick;
  logic                  found;

  // ----------------------------------------------------------------------------
  // Config port: always ready, write in access phase
  // ----------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= BASE_RESET;
      window_end    <= END_RESET;
      age_threshold <= THR_RESET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_BASE: window_base   <= pwdata;
        REG_END:  window_end    <= pwdata;
        REG_THR:  age_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_BASE: prdata = window_base;
      REG_END:  prdata = window_end;
      REG_THR:  prdata = {16'd0, age_threshold};
      default:  prdata = '0;
    endcase
  end

  // ----------------------------------------------------------------------------
  // Window check: one subtract plus compares
  // ----------------------------------------------------------------------------
  logic [31:0]      diff;
  logic             win_hit;
  logic [OPG_W-1:0] off_page;

  assign diff     = addr - window_base;
  assign win_hit  = (addr >= window_base) && (addr < window_end) &&
                    (diff < 32'(SHADOW_BYTES));
  assign off_page = diff[OFF_W-1:PAGE_SHIFT];

  // ----------------------------------------------------------------------------
  // Shadow RAM
  // ----------------------------------------------------------------------------
  logic       ram_we;
  logic [7:0] ram_rdata;

  // preload inside the window always stores, so a never-loaded byte gets a defined value
  assign ram_we = (state == ST_MEMCMP) && inwin && (cmd != CMD_READ) &&
                  ((cmd == CMD_PRELOAD) || (ram_rdata != wbyte));

  sfdpa_ram #(
    .WIDTH (8),
    .DEPTH (SHADOW_BYTES)
  ) u_shadow (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (off),
    .wr_data (wbyte),
    .rd_addr (off),
    .rd_data (ram_rdata)
  );

  // ----------------------------------------------------------------------------
  // Shared age unit: saturating increment of a nonzero age and threshold compare on one page
  // ----------------------------------------------------------------------------
  logic [AGE_W-1:0]      cur_age;
  logic [AGE_W-1:0]      inc_age;
  logic                  over;
  logic [PAGE_IDX_W-1:0] idx_wrap;
  logic [PAGE_IDX_W-1:0] ptr_wrap;

  assign cur_age  = page_age[age_idx];
  assign inc_age  = ((cur_age != '0) && (cur_age != AGE_MAX)) ? cur_age + 1'b1 : cur_age;
  assign over     = inc_age > age_threshold;
  assign idx_wrap = (age_idx == PAGE_IDX_W'(PAGE_COUNT - 1)) ? '0 : age_idx + 1'b1;
  assign ptr_wrap = (scan_ptr == PAGE_IDX_W'(PAGE_COUNT - 1)) ? '0 : scan_ptr + 1'b1;

  // ----------------------------------------------------------------------------
  // Sequencer
  // ----------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_ptr  <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
        page_age[i] <= '0;
      end
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cmd   <= in_data.command;
            addr  <= in_data.address;
            wbyte <= in_data.write_byte;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          inwin   <= win_hit;
          off     <= diff[OFF_W-1:0];
          page_ok <= {{(32-OPG_W){1'b0}}, off_page} < 32'(PAGE_COUNT);
          if (cmd == CMD_TICK) begin
            age_idx  <= ptr_wrap;
            scan_cnt <= '0;
            found    <= 1'b0;
            state    <= ST_SCAN;
          end else begin
            age_idx <= PAGE_IDX_W'(off_page);
            state   <= ST_MEMRD;
          end
        end
        ST_MEMRD: begin
          state <= ST_MEMCMP;
        end
        ST_MEMCMP: begin
          rdata_q <= ram_rdata;
          // first write that changes a byte marks the page; a running age is kept
          if (ram_we && (cmd == CMD_WRITE) && page_ok && (cur_age == '0)) begin
            page_age[age_idx] <= AGE_W'(1);
          end
          state <= ST_DONE;
        end
        ST_SCAN: begin
          if (!found && over) begin
            page_age[age_idx] <= '0;
            found             <= 1'b1;
            pick              <= age_idx;
          end else begin
            page_age[age_idx] <= inc_age;
          end
          age_idx  <= idx_wrap;
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == PAGE_IDX_W'(PAGE_COUNT - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data.read_byte    <= (cmd != CMD_READ) ? 8'd0 :
                                     (inwin ? rdata_q : OUTSIDE_BYTE);
            out_data.commit_valid <= (cmd == CMD_TICK) && found;
            out_data.commit_page  <= ((cmd == CMD_TICK) && found) ? 4'(pick) : 4'd0;
            if ((cmd == CMD_TICK) && found) begin
              scan_ptr <= pick;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ----------------------------------------------------------------------------
  // Assertions
  // ----------------------------------------------------------------------------
  `SFDPA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
  `SFDPA_ASSERT_NOW(a_commit_page_zero, out_valid && !out_data.commit_valid,
                    out_data.commit_page == 4'd0)
  `SFDPA_ASSERT_NOW(a_commit_no_read, out_valid && out_data.commit_valid,
                    out_data.read_byte == 8'd0)
  `SFDPA_ASSERT_NOW(a_commit_cleared, $rose(out_valid) && out_data.commit_valid,
                    (page_age[scan_ptr] == '0) && (4'(scan_ptr) == out_data.commit_page))

endmodule

>>> rtl/sfdpa_ram.sv
// Generic simple dual-port RAM with registered read.
module sfdpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
